// ===== sv/bds_pkg.sv =====
// Shared types, codes and constants for the bounded deck with shuffle.
// Depends on nothing; bds_rem, the deck and the testbench refer to it by scoped names.
`default_nettype none

package bds_pkg;

   localparam int RND_W        = 32;
   localparam int CAP_W        = 6;
   localparam int COUNT_W      = 6;
   localparam int HANDLE_W     = 16;
   localparam int KEY_W        = 32;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CAP_W-1:0] DEFAULT_CAPACITY = 6'd20;
   localparam logic [RND_W-1:0] LFSR_TAPS        = 32'h8020_0003;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_SHUFFLE = 2'd2,
      CMD_FIND    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 1'b0,
      CSR_SEED     = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_DRAW_RD,
      S_DRAW_WAIT,
      S_SH_RNG,
      S_SH_DIV,
      S_SH_RDA,
      S_SH_RDB,
      S_SH_WRA,
      S_SH_WRB,
      S_FIND_RD,
      S_FIND_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
   } entry_type;

   // Galois LFSR, right shift
   function automatic logic [RND_W-1:0] lfsr_next(input logic [RND_W-1:0] r);
      logic [RND_W-1:0] s;
      s = r >> 1;
      if (r[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== sv/bds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bds_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bds_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Depends on bds_pkg for the dividend width.
`default_nettype none

module bds_rem #(
   parameter int DIV_W = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [bds_pkg::RND_W-1:0]  dividend,
   input  wire logic [DIV_W-1:0]           divisor,
   output      logic                       done,
   output      logic [DIV_W-1:0]           remainder
);

   localparam int STEP_W = $clog2(bds_pkg::RND_W);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [bds_pkg::RND_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [DIV_W:0]            trial;
   logic [DIV_W:0]            trial_sub;
   logic                      last_step;

   assign trial     = {rem_ff, shift_ff[bds_pkg::RND_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign last_step = (step_ff == STEP_W'(bds_pkg::RND_W - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // keep the partial remainder below the divisor
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_sub[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         shift_in = shift_ff << 1;
         step_in  = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/bounded_deck_with_shuffle.sv =====
// Bounded deck with shuffle: a circular card store in one RAM, one command at a time.
// Each command is taken in idle and answered from a completion state; a find reads and
// checks one entry at a time, and a shuffle does count-1 swaps; each swap is one LFSR
// step, a division in the serial remainder unit and four RAM accesses.
// Throughput: one command at a time, the next taken once the result is parked.
// Synchronous reset empties the deck, sets capacity 20 and the generator 1; RAM is kept.
`default_nettype none

module bounded_deck_with_shuffle #(
   parameter int MAX_CARDS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [bds_pkg::HANDLE_W-1:0]    req_card_handle,
   input  wire logic [bds_pkg::KEY_W-1:0]       req_card_name_key,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [1:0]                      rsp_status,
   output      logic [bds_pkg::HANDLE_W-1:0]    rsp_found_handle,
   output      logic [bds_pkg::KEY_W-1:0]       rsp_found_name_key,
   output      logic [bds_pkg::COUNT_W-1:0]     rsp_entry_count,
   input  wire logic                            csr_wr_en,
   input  wire logic [bds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bds_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SLOT_W  = $clog2(MAX_CARDS);
   localparam int CNT_W   = $clog2(MAX_CARDS + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int CMP_W   = (CNT_W > bds_pkg::CAP_W) ? CNT_W : bds_pkg::CAP_W;
   localparam int ENTRY_W = $bits(bds_pkg::entry_type);

   bds_pkg::state_type              state_ff, state_in;
   logic [bds_pkg::CAP_W-1:0]       cap_ff, cap_in;
   logic [bds_pkg::RND_W-1:0]       rnd_ff, rnd_in;
   logic [SLOT_W-1:0]               front_ff, front_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                i_ff, i_in;
   logic [CNT_W-1:0]                b_ff, b_in;
   logic [CNT_W-1:0]                idx_ff, idx_in;
   bds_pkg::entry_type              tmp_ff, tmp_in;
   logic [bds_pkg::HANDLE_W-1:0]    handle_ff, handle_in;
   logic [bds_pkg::KEY_W-1:0]       key_ff, key_in;
   bds_pkg::status_type             res_status_ff, res_status_in;
   bds_pkg::entry_type              res_entry_ff, res_entry_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bds_pkg::status_type             rsp_status_ff, rsp_status_in;
   bds_pkg::entry_type              rsp_entry_ff, rsp_entry_in;
   logic [bds_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            req_xfer;
   logic                            rsp_free;
   logic                            deck_full;
   logic                            find_match;
   logic [CMP_W-1:0]                count_wide;
   logic [CNT_W-1:0]                ram_pos;
   logic [SUM_W-1:0]                slot_sum;
   logic [SUM_W-1:0]                slot_wrap;
   logic [SLOT_W-1:0]               ram_addr;
   logic                            ram_wr_en;
   logic                            ram_rd_en;
   bds_pkg::entry_type              ram_wr_data;
   bds_pkg::entry_type              ram_rd_data;
   logic                            rem_start;
   logic                            rem_done;
   logic [CNT_W-1:0]                rem_value;
   logic [bds_pkg::RND_W-1:0]       rnd_next;
   logic [bds_pkg::RND_W-1:0]       seed_value;

   assign req_xfer   = req_valid && !req_stall;
   assign req_stall  = (state_ff != bds_pkg::S_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign count_wide = CMP_W'(count_ff);
   assign deck_full  = (count_wide >= CMP_W'(cap_ff)) || (count_wide >= CMP_W'(MAX_CARDS));
   assign find_match = (ram_rd_data.key == key_ff);
   assign rnd_next   = bds_pkg::lfsr_next(rnd_ff);
   assign seed_value = (csr_wdata == '0) ? bds_pkg::RND_W'(1) : csr_wdata;

   // logical position to physical slot, wrapping once around the ring
   assign slot_sum  = SUM_W'(front_ff) + SUM_W'(ram_pos);
   assign slot_wrap = (slot_sum >= SUM_W'(MAX_CARDS)) ? (slot_sum - SUM_W'(MAX_CARDS))
                                                      : slot_sum;
   assign ram_addr  = slot_wrap[SLOT_W-1:0];

   bds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CARDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   bds_rem #(
      .DIV_W (CNT_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rnd_next),
      .divisor   (i_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bds_pkg::S_IDLE: begin
            if (req_xfer) begin
               case (bds_pkg::cmd_type'(req_cmd))
                  bds_pkg::CMD_ADD:     state_in = bds_pkg::S_ADD;
                  bds_pkg::CMD_DRAW:    state_in = bds_pkg::S_DRAW_RD;
                  bds_pkg::CMD_SHUFFLE: begin
                     if (count_ff < CNT_W'(2)) begin
                        state_in = bds_pkg::S_DONE;
                     end else begin
                        state_in = bds_pkg::S_SH_RNG;
                     end
                  end
                  bds_pkg::CMD_FIND:    state_in = bds_pkg::S_FIND_RD;
                  default:              state_in = bds_pkg::S_IDLE;
               endcase
            end
         end
         bds_pkg::S_ADD:       state_in = bds_pkg::S_DONE;
         bds_pkg::S_DRAW_RD: begin
            if (count_ff == '0) begin
               state_in = bds_pkg::S_DONE;
            end else begin
               state_in = bds_pkg::S_DRAW_WAIT;
            end
         end
         bds_pkg::S_DRAW_WAIT: state_in = bds_pkg::S_DONE;
         bds_pkg::S_SH_RNG:    state_in = bds_pkg::S_SH_DIV;
         bds_pkg::S_SH_DIV: begin
            if (rem_done) begin
               state_in = bds_pkg::S_SH_RDA;
            end
         end
         bds_pkg::S_SH_RDA:    state_in = bds_pkg::S_SH_RDB;
         bds_pkg::S_SH_RDB:    state_in = bds_pkg::S_SH_WRA;
         bds_pkg::S_SH_WRA:    state_in = bds_pkg::S_SH_WRB;
         bds_pkg::S_SH_WRB: begin
            if (i_ff == CNT_W'(2)) begin
               state_in = bds_pkg::S_DONE;
            end else begin
               state_in = bds_pkg::S_SH_RNG;
            end
         end
         bds_pkg::S_FIND_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = bds_pkg::S_DONE;
            end else begin
               state_in = bds_pkg::S_FIND_CHK;
            end
         end
         bds_pkg::S_FIND_CHK: begin
            if (find_match) begin
               state_in = bds_pkg::S_DONE;
            end else begin
               state_in = bds_pkg::S_FIND_RD;
            end
         end
         bds_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = bds_pkg::S_IDLE;
            end
         end
         default:              state_in = bds_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cap_in        = cap_ff;
      rnd_in        = rnd_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      tmp_in        = tmp_ff;
      handle_in     = handle_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_pos       = '0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_data   = tmp_ff;
      rem_start     = 1'b0;

      case (state_ff)
         bds_pkg::S_IDLE: begin
            if (req_xfer) begin
               handle_in    = req_card_handle;
               key_in       = req_card_name_key;
               i_in         = count_ff;
               idx_in       = '0;
               res_entry_in = '0;
               if (bds_pkg::cmd_type'(req_cmd) == bds_pkg::CMD_FIND) begin
                  res_status_in = bds_pkg::STAT_NOT_FOUND;
               end else begin
                  res_status_in = bds_pkg::STAT_OK;
               end
            end
         end
         bds_pkg::S_ADD: begin
            ram_pos = count_ff;
            if (deck_full) begin
               res_status_in = bds_pkg::STAT_FULL;
            end else begin
               ram_wr_en          = 1'b1;
               ram_wr_data.handle = handle_ff;
               ram_wr_data.key    = key_ff;
               count_in           = count_ff + CNT_W'(1);
            end
         end
         bds_pkg::S_DRAW_RD: begin
            if (count_ff == '0) begin
               res_status_in = bds_pkg::STAT_EMPTY;
            end else begin
               ram_rd_en = 1'b1;
            end
         end
         bds_pkg::S_DRAW_WAIT: begin
            res_entry_in = ram_rd_data;
            count_in     = count_ff - CNT_W'(1);
            if (front_ff == SLOT_W'(MAX_CARDS - 1)) begin
               front_in = '0;
            end else begin
               front_in = front_ff + SLOT_W'(1);
            end
         end
         bds_pkg::S_SH_RNG: begin
            rnd_in    = rnd_next;
            rem_start = 1'b1;
         end
         bds_pkg::S_SH_DIV: begin
            if (rem_done) begin
               b_in = rem_value;
            end
         end
         bds_pkg::S_SH_RDA: begin
            ram_pos   = i_ff - CNT_W'(1);
            ram_rd_en = 1'b1;
         end
         bds_pkg::S_SH_RDB: begin
            ram_pos   = b_ff;
            ram_rd_en = 1'b1;
            tmp_in    = ram_rd_data;
         end
         bds_pkg::S_SH_WRA: begin
            // hold read data of position j; write it to position i-1
            ram_pos     = i_ff - CNT_W'(1);
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
         end
         bds_pkg::S_SH_WRB: begin
            ram_pos     = b_ff;
            ram_wr_en   = 1'b1;
            ram_wr_data = tmp_ff;
            i_in        = i_ff - CNT_W'(1);
         end
         bds_pkg::S_FIND_RD: begin
            ram_pos = idx_ff;
            if (idx_ff < count_ff) begin
               ram_rd_en = 1'b1;
            end
         end
         bds_pkg::S_FIND_CHK: begin
            if (find_match) begin
               res_status_in = bds_pkg::STAT_OK;
               res_entry_in  = ram_rd_data;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         bds_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = count_wide[bds_pkg::COUNT_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         case (bds_pkg::csr_index_type'(csr_index))
            bds_pkg::CSR_CAPACITY: cap_in = csr_wdata[bds_pkg::CAP_W-1:0];
            bds_pkg::CSR_SEED:     rnd_in = seed_value;
            default:               cap_in = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bds_pkg::S_IDLE;
         cap_ff       <= bds_pkg::DEFAULT_CAPACITY;
         rnd_ff       <= bds_pkg::RND_W'(1);
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rnd_ff       <= rnd_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      b_ff          <= b_in;
      idx_ff        <= idx_in;
      tmp_ff        <= tmp_in;
      handle_ff     <= handle_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_handle   = rsp_entry_ff.handle;
   assign rsp_found_name_key = rsp_entry_ff.key;
   assign rsp_entry_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CARDS))
      else $error("deck count exceeds store size");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bds_pkg::S_SH_DIV) && rem_done |-> rem_value < i_ff)
      else $error("swap partner outside the unshuffled range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(rsp_valid_ff) && rsp_valid_ff |->
         $past(state_ff == bds_pkg::S_DONE))
      else $error("response raised outside the completion state");

endmodule

`default_nettype wire

// ===== tb/bounded_deck_with_shuffle_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deck_with_shuffle: queued card commands go through a
// clocked driver, and a clocked monitor compares each response with a shadow deck.
// Depends on bds_pkg and the bounded_deck_with_shuffle RTL.

module bounded_deck_with_shuffle_tb;

   localparam int DECK_SLOTS = 32;
   localparam int HANDLE_W   = bds_pkg::HANDLE_W;
   localparam int KEY_W      = bds_pkg::KEY_W;
   localparam int COUNT_W    = bds_pkg::COUNT_W;
   localparam int CAP_W      = bds_pkg::CAP_W;
   localparam int RND_W      = bds_pkg::RND_W;
   localparam int CSR_IDX_W  = bds_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = bds_pkg::CSR_DATA_W;

   typedef struct {
      bds_pkg::cmd_type     cmd;
      logic [HANDLE_W-1:0]  handle;
      logic [KEY_W-1:0]     key;
   } deck_op_type;

   typedef struct {
      bds_pkg::status_type  status;
      logic [HANDLE_W-1:0]  handle;
      logic [KEY_W-1:0]     key;
      logic [COUNT_W-1:0]   count;
   } deck_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_cmd = '0;
   logic [HANDLE_W-1:0]     req_card_handle = '0;
   logic [KEY_W-1:0]        req_card_name_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [HANDLE_W-1:0]     rsp_found_handle;
   logic [KEY_W-1:0]        rsp_found_name_key;
   logic [COUNT_W-1:0]      rsp_entry_count;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   bounded_deck_with_shuffle dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_card_handle    (req_card_handle),
      .req_card_name_key  (req_card_name_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_handle   (rsp_found_handle),
      .rsp_found_name_key (rsp_found_name_key),
      .rsp_entry_count    (rsp_entry_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // shadow deck
   logic [CAP_W-1:0]        sh_capacity = bds_pkg::DEFAULT_CAPACITY;
   logic [RND_W-1:0]        sh_rnd = 32'd1;
   logic [HANDLE_W-1:0]     sh_handle [DECK_SLOTS];
   logic [KEY_W-1:0]        sh_name [DECK_SLOTS];
   logic [4:0]              sh_front = '0;
   logic [COUNT_W-1:0]      sh_count = '0;

   deck_op_type             op_queue [$];
   deck_result_type         due_results [$];
   deck_op_type             drive_op;
   deck_result_type         want;
   int                      tx_gap = 0;
   int                      rx_hold = 0;
   bit                      tx_burst = 1'b0;
   bit                      rx_burst = 1'b0;
   int                      fail_count = 0;
   int                      rsp_seen = 0;
   logic [KEY_W-1:0]        key_pool [12];

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic deck_result_type predict_deck_result(deck_op_type op);
      deck_result_type   res;
      logic [CAP_W-1:0]  cap;
      logic [4:0]        sa;
      logic [4:0]        sb;
      logic [HANDLE_W-1:0] th;
      logic [KEY_W-1:0]  tk;
      logic [31:0]       i;
      res.status = bds_pkg::STAT_OK;
      res.handle = '0;
      res.key    = '0;
      cap = (sh_capacity > DECK_SLOTS) ? CAP_W'(DECK_SLOTS) : sh_capacity;
      case (op.cmd)
         bds_pkg::CMD_ADD: begin
            if (sh_count >= cap) begin
               res.status = bds_pkg::STAT_FULL;
            end else begin
               sa = sh_front + sh_count[4:0];
               sh_handle[sa] = op.handle;
               sh_name[sa]   = op.key;
               sh_count      = sh_count + 6'd1;
            end
         end
         bds_pkg::CMD_DRAW: begin
            if (sh_count == '0) begin
               res.status = bds_pkg::STAT_EMPTY;
            end else begin
               res.handle = sh_handle[sh_front];
               res.key    = sh_name[sh_front];
               sh_front   = sh_front + 5'd1;
               sh_count   = sh_count - 6'd1;
            end
         end
         bds_pkg::CMD_SHUFFLE: begin
            for (i = 32'(sh_count); i > 1; i--) begin
               // advance the generator before each swap
               sh_rnd = (sh_rnd >> 1) ^ (sh_rnd[0] ? bds_pkg::LFSR_TAPS : 32'd0);
               sa = sh_front + 5'(i - 1);
               sb = sh_front + 5'(sh_rnd % i);
               th = sh_handle[sa];
               tk = sh_name[sa];
               sh_handle[sa] = sh_handle[sb];
               sh_name[sa]   = sh_name[sb];
               sh_handle[sb] = th;
               sh_name[sb]   = tk;
            end
         end
         default: begin
            res.status = bds_pkg::STAT_NOT_FOUND;
            for (i = 0; i < 32'(sh_count); i++) begin
               sa = sh_front + 5'(i);
               if (res.status == bds_pkg::STAT_NOT_FOUND && sh_name[sa] == op.key) begin
                  res.status = bds_pkg::STAT_OK;
                  res.handle = sh_handle[sa];
                  res.key    = sh_name[sa];
               end
            end
         end
      endcase
      res.count = sh_count;
      return res;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("result %0d: %s is %h, expected %h", rsp_seen, field, got, exp_val);
      fail_count++;
   endtask

   // driver: hold the payload while stalled, predict on every transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            due_results.push_back(predict_deck_result(drive_op));
            tx_gap = draw_wait(tx_burst);
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap == 0 && op_queue.size() > 0) begin
               drive_op = op_queue.pop_front();
               req_valid         <= 1'b1;
               req_cmd           <= drive_op.cmd;
               req_card_handle   <= drive_op.handle;
               req_card_name_key <= drive_op.key;
            end else begin
               req_valid <= 1'b0;
               if (tx_gap > 0) begin
                  tx_gap--;
               end
            end
         end
      end
   end

   // monitor: check each transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result, status", 32'(rsp_status), 32'd0);
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_found_handle !== want.handle) begin
                  report_mismatch("found_handle", 32'(rsp_found_handle), 32'(want.handle));
               end
               if (rsp_found_name_key !== want.key) begin
                  report_mismatch("found_name_key", rsp_found_name_key, want.key);
               end
               if (rsp_entry_count !== want.count) begin
                  report_mismatch("entry_count", 32'(rsp_entry_count), 32'(want.count));
               end
            end
            rsp_seen++;
            rx_hold = draw_wait(rx_burst);
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   task automatic queue_op(input bds_pkg::cmd_type c, input logic [HANDLE_W-1:0] h,
                           input logic [KEY_W-1:0] k);
      deck_op_type o;
      o.cmd    = c;
      o.handle = h;
      o.key    = k;
      op_queue.push_back(o);
   endtask

   // block until every queued op has been transferred and answered
   task automatic wait_drained();
      @(negedge clock);
      while (op_queue.size() != 0 || req_valid || due_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input bds_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == bds_pkg::CSR_CAPACITY) begin
         sh_capacity = data[CAP_W-1:0];
      end else begin
         sh_rnd = (data == 0) ? 32'd1 : data;
      end
   endtask

   task automatic queue_random_ops(input int n, input int add_pct, input int draw_pct);
      int p;
      logic [KEY_W-1:0] k;
      for (int q = 0; q < n; q++) begin
         p = $urandom_range(0, 99);
         k = ($urandom_range(0, 99) < 72) ? key_pool[$urandom_range(0, 11)] : $urandom;
         if (p < add_pct) begin
            queue_op(bds_pkg::CMD_ADD, HANDLE_W'($urandom_range(0, 65535)), k);
         end else if (p < add_pct + draw_pct) begin
            queue_op(bds_pkg::CMD_DRAW, HANDLE_W'($urandom_range(0, 65535)), $urandom);
         end else if (p < add_pct + draw_pct + 8) begin
            queue_op(bds_pkg::CMD_SHUFFLE, HANDLE_W'($urandom_range(0, 65535)), $urandom);
         end else begin
            queue_op(bds_pkg::CMD_FIND, HANDLE_W'($urandom_range(0, 65535)), k);
         end
      end
   endtask

   initial begin
      logic [CAP_W-1:0]      caps [7];
      logic [CSR_DATA_W-1:0] seeds [7];
      int                    add_mix [7];
      int                    draw_mix [7];
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < 12; k++) begin
         key_pool[k] = $urandom;
      end
      caps  = '{6'd32, 6'd5, 6'd63, 6'd0, 6'd1, 6'($urandom_range(2, 31)), 6'd32};
      seeds = '{32'hFFFF_FFFF, 32'd0, $urandom, $urandom, 32'h8000_0000, $urandom, 32'd1};
      add_mix  = '{62, 25, 62, 30, 40, 45, 50};
      draw_mix = '{8, 45, 8, 40, 30, 25, 20};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty deck, single entry, duplicate keys, field extremes
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_FIND, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_SHUFFLE, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_ADD, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_SHUFFLE, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(bds_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(bds_pkg::CMD_ADD, 16'h1234, 32'h0000_0000);
      queue_op(bds_pkg::CMD_FIND, 16'hFFFF, 32'h0000_0000);
      queue_op(bds_pkg::CMD_FIND, 16'h0000, 32'hFFFF_FFFF);
      queue_op(bds_pkg::CMD_FIND, 16'h0000, 32'h5A5A_5A5A);
      queue_op(bds_pkg::CMD_SHUFFLE, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      wait_drained();
      csr_write(bds_pkg::CSR_CAPACITY, 32'd1);
      queue_op(bds_pkg::CMD_ADD, 16'hA5A5, 32'h1357_9BDF);
      queue_op(bds_pkg::CMD_ADD, 16'h5A5A, 32'h2468_ACE0);
      wait_drained();
      csr_write(bds_pkg::CSR_CAPACITY, 32'd0);
      queue_op(bds_pkg::CMD_ADD, 16'h0F0F, 32'hF0F0_F0F0);
      queue_op(bds_pkg::CMD_FIND, 16'h0000, 32'h1357_9BDF);
      queue_op(bds_pkg::CMD_DRAW, 16'h0000, 32'h0000_0000);
      wait_drained();

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(bds_pkg::CSR_CAPACITY, 32'(caps[ph]));
         csr_write(bds_pkg::CSR_SEED, seeds[ph]);
         tx_burst = (ph == 0 || ph == 3);
         rx_burst = (ph == 3 || ph == 5);
         queue_random_ops(50, add_mix[ph], draw_mix[ph]);
         // let the deck go quiet mid-phase before sending the rest
         wait_drained();
         queue_random_ops(50, add_mix[ph], draw_mix[ph]);
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0 && due_results.size() == 0) begin
         $display("** bounded_deck_with_shuffle: PASSED **");
      end else begin
         $display("** bounded_deck_with_shuffle: FAILED **");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("** bounded_deck_with_shuffle: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bds_pkg.sv
sv/bds_ram.sv
sv/bds_rem.sv
sv/bounded_deck_with_shuffle.sv
tb/bounded_deck_with_shuffle_tb.sv
